// ----- sv/pss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants of the path shortcut splicer
// Field widths, operation codes and configuration register map.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int OP_W   = 1;
  localparam int NODE_W = 10;
  localparam int HOP_W  = 10;

  typedef enum logic [OP_W-1:0] {
    OP_RESTART  = 1'b0,
    OP_SHORTCUT = 1'b1
  } op_t;

  // APB register map: one 32-bit register per 4-byte slot
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam int             NODE_COUNT_W     = 11;
  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

  // register index as decoded from paddr[2]
  localparam logic REG_NODE_COUNT = 1'b0;

endpackage

// ----- sv/pss_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_if: valid/ready channels of the path shortcut splicer
// Command channel (operation, from_node, to_node) and response channel
// (hop_count, ignored).
// ----------------------------------------------------------------------------
interface pss_cmd_if
  import pss_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [NODE_W-1:0] from_node;
  logic [NODE_W-1:0] to_node;

  modport source (output valid, output operation, output from_node, output to_node,
                  input ready);
  modport sink   (input valid, input operation, input from_node, input to_node,
                  output ready);
endinterface

interface pss_rsp_if
  import pss_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [HOP_W-1:0] hop_count;
  logic             ignored;

  modport source (output valid, output hop_count, output ignored, input ready);
  modport sink   (input valid, input hop_count, input ignored, output ready);
endinterface

// ----- sv/pss_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/path_shortcut_splicer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_shortcut_splicer: forward chain with range splice and live-edge count
// Keeps a chain over nodes 0..n-1 in one RAM and splices shortcuts into it.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one word per operation: restart (rebuild the chain from
//   node_count) or add shortcut (from_node -> to_node). rsp returns one word
//   per command: hop_count, the live-edge count after the command, and
//   ignored, set when an index is at or past n or to_node is not above
//   from_node. The user writes node_count (APB offset 0) only while idle;
//   unenforced. It is saturated to [2, MAX_NODES] and applied at next restart.
// Timing:
//   cmd.ready is high only while idle; one command is worked at a time.
//   A rejected shortcut goes from idle straight to the response state; a
//   no-effect shortcut first reads its from node. An applied shortcut reads
//   it, then walks the chain one node per cycle through the single RAM read
//   port, then writes the splice. Restart rewrites one RAM entry per cycle.
// Reset:
//   rst starts the same rebuild pass for n = saturated reset node_count
//   with no response word; cmd.ready stays low during the pass.
// Stall:
//   rsp is a register. A finished word waits there while the next command
//   is taken; a further result waits until rsp.ready frees the register.
// ----------------------------------------------------------------------------
module path_shortcut_splicer
  import pss_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  pss_cmd_if.sink           cmd,
  pss_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // node index, node value (up to MAX_NODES) and compare widths
  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int CW    = (NW > NODE_COUNT_W) ? NW : NODE_COUNT_W;
  localparam int ENT_W = NW + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK_FROM,
    S_WALK,
    S_FIN,
    S_RESP
  } state_t;

  function automatic logic [CW-1:0] sat_count(input logic [NODE_COUNT_W-1:0] nc);
    logic [CW-1:0] v;
    v = CW'(nc);
    if (v < CW'(2)) begin
      sat_count = CW'(2);
    end else if (v > CW'(MAX_NODES)) begin
      sat_count = CW'(MAX_NODES);
    end else begin
      sat_count = v;
    end
  endfunction

  localparam logic [CW-1:0] N_RESET = sat_count(NODE_COUNT_RESET);

  // ---------------------------------------------------------------- registers
  state_t                  state;
  logic [NODE_COUNT_W-1:0] node_count;
  logic [CW-1:0]           n_act;      // active node count latched at restart
  logic [IDX_W-1:0]        edge_count;
  logic [IDX_W-1:0]        clr_idx;
  logic                    clr_reply;  // restart pass owes a response
  logic [CW-1:0]           from_q;
  logic [CW-1:0]           to_q;
  logic [CW-1:0]           v_q;        // node being visited by the walk
  logic                    bad_q;

  // ---------------------------------------------------------------- RAM port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  pss_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_NODES)
  ) u_chain (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entry layout: {live, next}
  logic          ent_live;
  logic [CW-1:0] ent_next;
  assign ent_live = ram_rdata[NW];
  assign ent_next = CW'(ram_rdata[NW-1:0]);

  // ---------------------------------------------------------------- decode
  logic [CW-1:0] cmd_from;
  logic [CW-1:0] cmd_to;
  logic          cmd_bad;
  logic          cmd_take;
  logic          walk_stop;
  logic [CW-1:0] count_ext;
  logic          rsp_free;

  assign cmd_from  = CW'(cmd.from_node);
  assign cmd_to    = CW'(cmd.to_node);
  assign cmd_bad   = (cmd_from >= n_act) || (cmd_to >= n_act) || (cmd_to <= cmd_from);
  assign cmd.ready = (state == S_IDLE);
  assign cmd_take  = cmd.valid && cmd.ready;
  // stop once the next hop reaches the shortcut end (or fails to advance)
  assign walk_stop = (ent_next <= v_q) || (ent_next >= to_q);
  assign count_ext = CW'(edge_count);
  assign rsp_free  = !rsp.valid || rsp.ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = {1'b1, NW'(clr_idx) + NW'(1)};
    ram_raddr = cmd_from[IDX_W-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_raddr = cmd_from[IDX_W-1:0];
      end
      S_CHK_FROM: begin
        ram_raddr = ent_next[IDX_W-1:0];
      end
      S_WALK: begin
        // drop the visited node and fetch its successor in the same cycle
        ram_we    = ent_live;
        ram_waddr = v_q[IDX_W-1:0];
        ram_wdata = {1'b0, ram_rdata[NW-1:0]};
        ram_raddr = ent_next[IDX_W-1:0];
      end
      S_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = from_q[IDX_W-1:0];
        ram_wdata = {1'b1, to_q[NW-1:0]};
      end
      S_RESP: begin
        ram_raddr = from_q[IDX_W-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      node_count <= NODE_COUNT_RESET;
      n_act      <= N_RESET;
      edge_count <= IDX_W'(N_RESET - CW'(1));
      clr_idx    <= '0;
      clr_reply  <= 1'b0;
      bad_q      <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      // APB write: register taken on the access phase
      if (psel && penable && pwrite && pready && (paddr[2] == REG_NODE_COUNT)) begin
        node_count <= pwdata[NODE_COUNT_W-1:0];
      end

      // drop the word once taken, unless a new one is loaded below
      if (rsp.valid && rsp.ready && (state != S_RESP)) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (CW'(clr_idx) == n_act - CW'(1)) begin
            clr_idx <= '0;
            state   <= clr_reply ? S_RESP : S_IDLE;
          end else begin
            clr_idx <= clr_idx + IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (cmd_take) begin
            from_q <= cmd_from;
            to_q   <= cmd_to;
            bad_q  <= 1'b0;
            if (cmd.operation == OP_RESTART) begin
              n_act      <= sat_count(node_count);
              edge_count <= IDX_W'(sat_count(node_count) - CW'(1));
              clr_idx    <= '0;
              clr_reply  <= 1'b1;
              state      <= S_CLEAR;
            end else if (cmd_bad) begin
              bad_q <= 1'b1;
              state <= S_RESP;
            end else begin
              state <= S_CHK_FROM;
            end
          end
        end
        S_CHK_FROM: begin
          if (ent_live && (ent_next < to_q)) begin
            v_q   <= ent_next;
            state <= S_WALK;
          end else begin
            state <= S_RESP;
          end
        end
        S_WALK: begin
          if (ent_live && (edge_count != '0)) begin
            edge_count <= edge_count - IDX_W'(1);
          end
          v_q <= ent_next;
          if (walk_stop) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp_free) begin
            rsp.valid     <= 1'b1;
            rsp.hop_count <= count_ext[HOP_W-1:0];
            rsp.ignored   <= bad_q;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- APB read
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? APB_DW'(node_count) : '0;

  // ---------------------------------------------------------------- checks
  a_walk_below_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (v_q < to_q) && (v_q > from_q))
    else $error("walk visits a node outside the shortcut span");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_ext <= n_act - CW'(1))
    else $error("edge count above active node count");

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> (state != S_IDLE))
    else $error("accepted command did not start work");

  a_chk_after_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK_FROM) |-> ($past(state) == S_IDLE))
    else $error("from-node check without a fresh read");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("chain RAM written while idle");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the path shortcut splicer
// Sends restart and shortcut words under several node counts and compares
// each returned word with the hop count and ignored flag that a chain
// model, kept in step with every accepted command, predicts.
// ----------------------------------------------------------------------------
module tb;
  import pss_pkg::*;

  localparam int NODE_SLOTS  = 1024;   // MAX_NODES of the instance below
  localparam int QUIET_LIMIT = 20000;  // well above the longest restart or walk
  localparam logic [APB_AW-1:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};

  typedef struct packed {
    logic [HOP_W-1:0] hop_count;
    logic             ignored;
  } hop_word_t;

  // Chain model plus the queue of hop words it still owes.
  class hop_scoreboard;
    logic [NODE_COUNT_W-1:0] node_count;
    int unsigned             active_n;
    int unsigned             next_ptr [NODE_SLOTS];
    bit                      live [NODE_SLOTS];
    int unsigned             edge_total;
    hop_word_t               pending_hops [$];
    int unsigned             mismatch_count;

    function new();
      node_count     = NODE_COUNT_RESET;
      mismatch_count = 0;
      rebuild_chain();
    endfunction

    function void rebuild_chain();
      active_n = 32'(node_count);
      if (active_n < 2) active_n = 2;
      if (active_n > NODE_SLOTS) active_n = NODE_SLOTS;
      foreach (next_ptr[k]) begin
        next_ptr[k] = k + 1;
        live[k]     = 1'b1;
      end
      edge_total = active_n - 1;
    endfunction

    // Apply one accepted command, queue its hop word; returns the ignored flag.
    function bit note_command(op_t op, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
      int unsigned s, d, v, w, cleared;
      hop_word_t   word;
      bit          bad;
      s   = 32'(src);
      d   = 32'(dst);
      bad = 1'b0;
      if (op == OP_RESTART) begin
        rebuild_chain();
      end else if (s >= active_n || d >= active_n || d <= s) begin
        bad = 1'b1;
      end else if (live[s] && next_ptr[s] < d) begin
        v       = next_ptr[s];
        cleared = 0;
        while (v < d) begin
          w = next_ptr[v];
          if (live[v]) begin
            live[v] = 1'b0;
            cleared++;
          end
          if (w <= v) break;
          v = w;
        end
        next_ptr[s] = d;
        edge_total  = (cleared > edge_total) ? 0 : edge_total - cleared;
      end
      word.hop_count = edge_total[HOP_W-1:0];
      word.ignored   = bad;
      pending_hops.insert(pending_hops.size(), word);
      return bad;
    endfunction

    task report(string what);
      mismatch_count++;
      $display("ERROR: %s", what);
    endtask

    task check_word(logic [HOP_W-1:0] hop, logic ign);
      hop_word_t want;
      if (pending_hops.size() == 0) begin
        report($sformatf("hop word with nothing pending: hop_count=%0d ignored=%0b",
                         hop, ign));
        return;
      end
      want = pending_hops.pop_front();
      if (hop !== want.hop_count)
        report($sformatf("hop_count %0d, predicted %0d", hop, want.hop_count));
      if (ign !== want.ignored)
        report($sformatf("ignored %0b, predicted %0b", ign, want.ignored));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              steady;      // high: neither side idles
  int unsigned       quiet_cycles;
  int unsigned       sent_items;

  hop_scoreboard sb;

  pss_cmd_if cmd_ch ();
  pss_rsp_if rsp_ch ();

  path_shortcut_splicer i_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Write node_count over APB: setup cycle, then access until pready.
  task automatic write_node_count(logic [NODE_COUNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NODE_COUNT_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.node_count = value;
  endtask

  // Offer one command word, maybe after a random idle gap, and hold it until
  // the block takes it. valid stays high afterwards so back-to-back words
  // never see a lowered-and-raised valid in one step.
  task automatic issue(op_t op, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
    if (!steady && $urandom_range(99) < 14) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 40) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.from_node <= src;
    cmd_ch.to_node   <= dst;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    void'(sb.note_command(op, src, dst));
    sent_items++;
  endtask

  // Drop valid and hold off until every predicted word has come back, then
  // let the block settle before the register is touched.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_hops.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pick a live node below n-1: node 0 is never cleared, so the search ends.
  function automatic logic [NODE_W-1:0] pick_live(int unsigned n);
    int r;
    r = $urandom_range(n - 2, 0);
    while (!sb.live[r]) r--;
    return r[NODE_W-1:0];
  endfunction

  // Mostly well-formed shortcuts from live nodes, with rare restarts and
  // some full-range noise that is usually out of range or reversed.
  task automatic random_phase(int unsigned words);
    int unsigned n, nx, src, dst, roll;
    for (int k = 0; k < words; k++) begin
      n    = sb.active_n;
      roll = $urandom_range(99);
      if (roll < 6) begin
        issue(OP_RESTART, NODE_W'($urandom_range(1023)), NODE_W'($urandom_range(1023)));
      end else if (roll < 20) begin
        issue(OP_SHORTCUT, NODE_W'($urandom_range(1023)), NODE_W'($urandom_range(1023)));
      end else begin
        src = 32'(pick_live(n));
        nx  = sb.next_ptr[src];
        if (nx + 1 < n && $urandom_range(99) < 80)
          dst = $urandom_range(n - 1, nx + 1);   // splices at least one node
        else
          dst = $urandom_range(n - 1, src + 1);  // may have no effect
        issue(OP_SHORTCUT, NODE_W'(src), NODE_W'(dst));
      end
    end
  endtask

  // Response side: random stalls on ready, none while steady.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_word(rsp_ch.hop_count, rsp_ch.ignored);
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned phase;
    logic [NODE_COUNT_W-1:0] count_value;
    sb = new();
    sent_items = 0;
    phase      = 0;
    rst              <= 1'b1;
    steady           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.operation <= OP_RESTART;
    cmd_ch.from_node <= '0;
    cmd_ch.to_node   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset chain of 1024 nodes.
    issue(OP_SHORTCUT, 10'd5, 10'd3);       // reversed range
    issue(OP_SHORTCUT, 10'd7, 10'd7);       // empty range
    issue(OP_SHORTCUT, 10'd1023, 10'd0);    // top node as start
    issue(OP_SHORTCUT, 10'd0, 10'd1);       // already the next node
    issue(OP_SHORTCUT, 10'd2, 10'd5);       // splice out 3 and 4
    issue(OP_SHORTCUT, 10'd3, 10'd9);       // start node no longer live
    issue(OP_SHORTCUT, 10'd2, 10'd4);       // next already past the target
    issue(OP_SHORTCUT, 10'd1, 10'd10);      // walk jumps over a spliced gap
    issue(OP_SHORTCUT, 10'd0, 10'd1023);    // collapse the whole chain
    issue(OP_SHORTCUT, 10'd1022, 10'd1023); // cleared start
    issue(OP_SHORTCUT, 10'd0, 10'd1023);    // repeat has no effect
    issue(OP_RESTART, 10'd1023, 10'd1023);  // unused fields all ones
    issue(OP_SHORTCUT, 10'd1023, 10'd1023);
    issue(OP_SHORTCUT, 10'd0, 10'd0);
    issue(OP_SHORTCUT, 10'd1021, 10'd1023);
    // Node count below the floor saturates to two nodes.
    drain_results();
    write_node_count(11'd0);
    issue(OP_RESTART, 10'd0, 10'd0);
    issue(OP_SHORTCUT, 10'd0, 10'd1);
    issue(OP_SHORTCUT, 10'd0, 10'd2);       // past the end of a short chain
    issue(OP_SHORTCUT, 10'd1, 10'd1023);
    // Node count above the ceiling saturates to MAX_NODES.
    drain_results();
    write_node_count(11'd2047);
    issue(OP_RESTART, 10'd512, 10'd1);
    issue(OP_SHORTCUT, 10'd512, 10'd1023);
    drain_results();
    write_node_count(11'd2);
    issue(OP_RESTART, 10'd0, 10'd0);

    // Random phases: new node count, restart, then a burst of commands.
    while (sent_items < 550) begin
      steady <= (phase == 2 || phase == 3);
      drain_results();
      case ($urandom_range(9))
        0: begin
          case ($urandom_range(4))
            0: count_value = 11'd0;
            1: count_value = 11'd1;
            2: count_value = 11'd2;
            3: count_value = 11'd2047;
            default: count_value = NODE_COUNT_W'($urandom_range(2047));
          endcase
        end
        1: count_value = 11'd1024;
        default: count_value = NODE_COUNT_W'($urandom_range(64, 3));
      endcase
      write_node_count(count_value);
      issue(OP_RESTART, NODE_W'($urandom_range(1023)), NODE_W'($urandom_range(1023)));
      random_phase(30 + $urandom_range(20));
      phase++;
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- path_shortcut_splicer.f -----
sv/pss_pkg.sv
sv/pss_if.sv
sv/pss_ram.sv
sv/path_shortcut_splicer.sv
verif/tb.sv
